### hdl/at_command_suffix_parser_macros.svh
// Assertion macros used by the suffix parser control module.
`ifndef AT_COMMAND_SUFFIX_PARSER_MACROS_SVH
`define AT_COMMAND_SUFFIX_PARSER_MACROS_SVH

`ifndef SYNTHESIS
`define ACSP_ASSERT_IMPL(lbl, cond, consq) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (consq)) \
		else $error("acsp: assertion failed");
`define ACSP_ASSERT_NEXT(lbl, cond, consq) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (consq)) \
		else $error("acsp: assertion failed");
`else
`define ACSP_ASSERT_IMPL(lbl, cond, consq)
`define ACSP_ASSERT_NEXT(lbl, cond, consq)
`endif

`endif

### hdl/acsp_pkg.sv
// Package for the AT command suffix parser: constants, types and helpers.
package acsp_pkg;

	localparam int MAX_TOKEN  = 32;
	localparam int MAX_PARAMS = 16;
	localparam int TOK_AW     = $clog2(MAX_TOKEN);
	localparam int TOK_LW     = $clog2(MAX_TOKEN + 1);
	localparam int CNT_W      = $clog2(MAX_PARAMS + 1);
	localparam int IDX_W      = 4;
	localparam int TDATA_W    = 24;
	localparam int ADDR_W     = 4;
	localparam int PDATA_W    = 32;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_QM     = 8'h3F;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	typedef enum logic [2:0] {
		PH_FIRST, PH_AFTER_EQ, PH_PARAMS, PH_READ, PH_TEST, PH_BAD
	} phase_t;

	typedef enum logic [1:0] {
		CT_IDLE, CT_RD, CT_OUT, CT_REP
	} ctl_state_t;

	typedef enum logic [1:0] {
		TY_ACT = 2'd0, TY_TEST = 2'd1, TY_PARA = 2'd2, TY_READ = 2'd3
	} cmd_type_t;

	typedef enum logic [1:0] {
		ST_LOCAL = 2'd0, ST_FWD = 2'd1, ST_ERR = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		RG_ALLOWED = 2'd0, RG_MIN = 2'd1, RG_MAX = 2'd2
	} reg_idx_t;

	localparam logic KIND_TOKEN  = 1'b0;
	localparam logic KIND_REPORT = 1'b1;

	typedef struct packed {
		logic [3:0] allowed_types;
		logic [3:0] min_params;
		logic [3:0] max_params;
	} cfg_t;

	typedef struct packed {
		logic              we;
		logic [TOK_AW-1:0] waddr;
		logic [7:0]        wdata;
		logic              re;
		logic [TOK_AW-1:0] raddr;
	} ram_req_t;

	function automatic status_t dispatch(input cfg_t cfg, input cmd_type_t ty,
	                                     input logic [CNT_W-1:0] cnt);
		status_t st;
		st = ST_LOCAL;
		if (!cfg.allowed_types[ty])
			st = ST_FWD;
		else if (ty == TY_PARA && (cnt < CNT_W'(cfg.min_params) ||
		                           cnt > CNT_W'(cfg.max_params)))
			st = ST_FWD;
		return st;
	endfunction

endpackage

### hdl/acsp_regs.sv
// Configuration register file with APB-style access.
module acsp_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [acsp_pkg::ADDR_W-1:0]   paddr,
	input  logic [acsp_pkg::PDATA_W-1:0]  pwdata,
	output logic [acsp_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	output acsp_pkg::cfg_t                cfg
);
	import acsp_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr     = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.allowed_types <= 4'hF;
			cfg_q.min_params    <= 4'h0;
			cfg_q.max_params    <= 4'hF;
		end else if (wr) begin
			case (idx)
				RG_ALLOWED: cfg_q.allowed_types <= pwdata[3:0];
				RG_MIN:     cfg_q.min_params    <= pwdata[3:0];
				RG_MAX:     cfg_q.max_params    <= pwdata[3:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			RG_ALLOWED: prdata = PDATA_W'(cfg_q.allowed_types);
			RG_MIN:     prdata = PDATA_W'(cfg_q.min_params);
			RG_MAX:     prdata = PDATA_W'(cfg_q.max_params);
			default:    prdata = '0;
		endcase
	end

endmodule

### hdl/acsp_token_ram.sv
// Token byte store: one write port, one registered read port.
module acsp_token_ram (
	input  logic               clk,
	input  acsp_pkg::ram_req_t req,
	output logic [7:0]         rdata
);
	import acsp_pkg::*;

	logic [7:0] mem [MAX_TOKEN];

	always_ff @(posedge clk) begin
		if (req.we)
			mem[req.waddr] <= req.wdata;
		if (req.re)
			rdata <= mem[req.raddr];
	end

endmodule

### hdl/acsp_ctrl.sv
// Parser control: byte decode, token flush sequencer and output register.
`include "at_command_suffix_parser_macros.svh"

module acsp_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  acsp_pkg::cfg_t                 cfg,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [7:0]                     s_tdata,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [acsp_pkg::TDATA_W-1:0]   m_tdata,
	output logic [0:0]                     m_tuser,
	output logic                           m_tlast,
	output acsp_pkg::ram_req_t             ram_req,
	input  logic [7:0]                     ram_rdata
);
	import acsp_pkg::*;

	ctl_state_t        state_q, state_n;
	phase_t            ph_q, ph_n;
	logic              ins_q, ins_n;
	logic              esc_q, esc_n;
	logic              err_q, err_n;
	logic [TOK_LW-1:0] len_q, len_n;
	logic [CNT_W-1:0]  cnt_q, cnt_n;

	// flush and report bookkeeping
	logic [TOK_LW-1:0] flen_q;
	logic [TOK_AW-1:0] ctr_q;
	logic [IDX_W-1:0]  fidx_q;
	logic              rep_pend_q;
	cmd_type_t         rep_type_q;
	logic [CNT_W-1:0]  rep_total_q;
	status_t           rep_st_q;

	// output register
	logic              ovalid_q;
	logic              okind_q;
	logic [7:0]        obyte_q;
	logic [IDX_W-1:0]  oidx_q;
	logic              oend_q;
	cmd_type_t         otype_q;
	logic [CNT_W-1:0]  ototal_q;
	status_t           ost_q;
	logic              olast_q;

	logic              acc, out_free, last_byte;
	logic              pb, app, fl, rep, esc_hit, err_f;
	logic [CNT_W-1:0]  cnt_f;
	cmd_type_t         rep_type;
	logic [CNT_W-1:0]  rep_total;
	status_t           rep_st;
	logic              ld_tok, ld_rep;
	logic [7:0]        c;

	assign c         = s_tdata;
	assign s_tready  = (state_q == CT_IDLE);
	assign acc       = s_tvalid && s_tready;
	assign out_free  = !ovalid_q || m_tready;
	assign last_byte = (TOK_LW'(ctr_q) + TOK_LW'(1)) == flen_q;

	// byte decode
	always_comb begin
		ph_n      = ph_q;
		ins_n     = ins_q;
		esc_n     = esc_q;
		err_n     = err_q;
		len_n     = len_q;
		cnt_n     = cnt_q;
		pb        = 1'b0;
		app       = 1'b0;
		fl        = 1'b0;
		rep       = 1'b0;
		esc_hit   = 1'b0;
		err_f     = 1'b0;
		cnt_f     = cnt_q;
		rep_type  = TY_ACT;
		rep_total = '0;
		rep_st    = ST_LOCAL;

		case (ph_q)
			PH_AFTER_EQ: begin
				if (c == CH_QM) begin
					ph_n = PH_TEST;
				end else begin
					ph_n = PH_PARAMS;
					pb   = 1'b1;
				end
			end
			PH_PARAMS: pb = 1'b1;
			PH_READ: begin
				if (c == CH_NUL) begin
					rep      = 1'b1;
					rep_type = TY_READ;
					rep_st   = dispatch(cfg, TY_READ, '0);
				end
			end
			PH_TEST: begin
				if (c == CH_NUL) begin
					rep      = 1'b1;
					rep_type = TY_TEST;
					rep_st   = dispatch(cfg, TY_TEST, '0);
				end
			end
			PH_BAD: begin
				if (c == CH_NUL) begin
					rep    = 1'b1;
					rep_st = ST_ERR;
				end
			end
			default: begin
				if (c == CH_NUL) begin
					rep    = 1'b1;
					rep_st = dispatch(cfg, TY_ACT, '0);
				end else if (c == CH_EQ) begin
					ph_n = PH_AFTER_EQ;
				end else if (c == CH_QM) begin
					ph_n = PH_READ;
				end else begin
					ph_n = PH_BAD;
				end
			end
		endcase

		if (pb) begin
			if (err_q) begin
				if (c == CH_NUL) begin
					rep       = 1'b1;
					rep_type  = TY_PARA;
					rep_total = cnt_q;
					rep_st    = ST_ERR;
				end
			end else begin
				esc_hit = esc_q && (c == CH_QUOTE);
				if (esc_q)
					esc_n = 1'b0;
				if (esc_hit) begin
					app = 1'b1;
				end else if (c == CH_QUOTE && !ins_q) begin
					len_n = '0;
					ins_n = 1'b1;
				end else if (c == CH_QUOTE || c == CH_NUL || (c == CH_COMMA && !ins_q)) begin
					if (c == CH_QUOTE)
						ins_n = 1'b0;
					if (len_q != '0) begin
						if (cnt_q >= CNT_W'(MAX_PARAMS)) begin
							err_f = 1'b1;
						end else begin
							fl    = 1'b1;
							cnt_f = cnt_q + CNT_W'(1);
						end
					end
					len_n = '0;
					cnt_n = cnt_f;
					err_n = err_f;
					if (c == CH_NUL) begin
						rep       = 1'b1;
						rep_type  = TY_PARA;
						rep_total = cnt_f;
						rep_st    = (err_f || ins_q) ? ST_ERR : dispatch(cfg, TY_PARA, cnt_f);
					end
				end else if (c == CH_BSLASH && ins_q) begin
					esc_n = 1'b1;
					app   = 1'b1;
				end else if (c == CH_SPACE && !ins_q && len_q == '0) begin
					app = 1'b0;
				end else begin
					app = 1'b1;
				end
			end
		end

		if (app && len_q < TOK_LW'(MAX_TOKEN))
			len_n = len_q + TOK_LW'(1);

		if (rep) begin
			ph_n  = PH_FIRST;
			ins_n = 1'b0;
			esc_n = 1'b0;
			err_n = 1'b0;
			len_n = '0;
			cnt_n = '0;
		end
	end

	// store port: appends only in idle, reads only while flushing
	always_comb begin
		ram_req.we    = acc && app && (len_q < TOK_LW'(MAX_TOKEN));
		ram_req.waddr = len_q[TOK_AW-1:0];
		ram_req.wdata = c;
		ram_req.re    = (state_q == CT_RD);
		ram_req.raddr = ctr_q;
	end

	// sequencer
	always_comb begin
		state_n = state_q;
		ld_tok  = 1'b0;
		ld_rep  = 1'b0;
		case (state_q)
			CT_IDLE: begin
				if (acc) begin
					if (fl)
						state_n = CT_RD;
					else if (rep)
						state_n = CT_REP;
				end
			end
			CT_RD: state_n = CT_OUT;
			CT_OUT: begin
				if (out_free) begin
					ld_tok = 1'b1;
					if (!last_byte)
						state_n = CT_RD;
					else if (rep_pend_q)
						state_n = CT_REP;
					else
						state_n = CT_IDLE;
				end
			end
			CT_REP: begin
				if (out_free) begin
					ld_rep  = 1'b1;
					state_n = CT_IDLE;
				end
			end
			default: state_n = CT_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= CT_IDLE;
		else
			state_q <= state_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q       <= PH_FIRST;
			ins_q      <= 1'b0;
			esc_q      <= 1'b0;
			err_q      <= 1'b0;
			len_q      <= '0;
			cnt_q      <= '0;
			rep_pend_q <= 1'b0;
			ctr_q      <= '0;
			ovalid_q   <= 1'b0;
		end else begin
			if (acc) begin
				ph_q       <= ph_n;
				ins_q      <= ins_n;
				esc_q      <= esc_n;
				err_q      <= err_n;
				len_q      <= len_n;
				cnt_q      <= cnt_n;
				rep_pend_q <= rep;
				ctr_q      <= '0;
			end else if (ld_tok) begin
				ctr_q <= ctr_q + TOK_AW'(1);
			end
			if (ld_tok || ld_rep)
				ovalid_q <= 1'b1;
			else if (m_tready)
				ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			flen_q      <= len_q;
			fidx_q      <= cnt_q[IDX_W-1:0];
			rep_type_q  <= rep_type;
			rep_total_q <= rep_total;
			rep_st_q    <= rep_st;
		end
		if (ld_tok) begin
			okind_q  <= KIND_TOKEN;
			obyte_q  <= ram_rdata;
			oidx_q   <= fidx_q;
			oend_q   <= last_byte;
			otype_q  <= TY_ACT;
			ototal_q <= '0;
			ost_q    <= ST_LOCAL;
			olast_q  <= last_byte && !rep_pend_q;
		end else if (ld_rep) begin
			okind_q  <= KIND_REPORT;
			obyte_q  <= '0;
			oidx_q   <= '0;
			oend_q   <= 1'b0;
			otype_q  <= rep_type_q;
			ototal_q <= rep_total_q;
			ost_q    <= rep_st_q;
			olast_q  <= 1'b1;
		end
	end

	assign m_tvalid = ovalid_q;
	assign m_tuser  = okind_q;
	assign m_tlast  = olast_q;
	assign m_tdata  = TDATA_W'({ost_q, ototal_q, otype_q, oend_q, oidx_q, obyte_q});

	`ACSP_ASSERT_IMPL(a_len_bound, 1'b1, len_q <= TOK_LW'(MAX_TOKEN))
	`ACSP_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(MAX_PARAMS))
	`ACSP_ASSERT_IMPL(a_flush_in_range, state_q == CT_OUT, TOK_LW'(ctr_q) < flen_q)
	`ACSP_ASSERT_NEXT(a_rep_follows, ld_tok && last_byte && rep_pend_q, state_q == CT_REP)
	`ACSP_ASSERT_IMPL(a_no_write_in_flush, state_q != CT_IDLE, !ram_req.we)

endmodule

### hdl/at_command_suffix_parser.sv
// AT command suffix parser top level.
// Takes the suffix of an AT command one byte per transaction and returns token bytes and a
// final report on the master stream. A byte that closes neither a token nor a command keeps
// the input ready; one that closes a token holds it while the flush sequencer reads the
// token store once per byte, each read passing the registered read port (CT_RD) before its
// data reaches the output register (CT_OUT); one that closes a command holds it while the
// report passes CT_REP; output back-pressure lengthens it. Registers: byte addresses 0, 4, 8.
module at_command_suffix_parser (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [acsp_pkg::ADDR_W-1:0]   paddr,
	input  logic [acsp_pkg::PDATA_W-1:0]  pwdata,
	output logic [acsp_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // [7:0] text_byte
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [7:0] token_byte, [11:8] param_index, [12] token_end, [14:13] command_type,
	// [19:15] param_total, [21:20] dispatch_status, [23:22] zero
	output logic [acsp_pkg::TDATA_W-1:0]  m_tdata,
	output logic [0:0]                    m_tuser,   // [0] result_kind
	output logic                          m_tlast    // run_last
);
	import acsp_pkg::*;

	cfg_t       cfg;
	ram_req_t   ram_req;
	logic [7:0] ram_rdata;

	acsp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	acsp_token_ram u_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (ram_rdata)
	);

	acsp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata)
	);

endmodule

### sim/tb.sv
// Self-checking testbench for the AT command suffix parser: streams command text, predicts results.
`timescale 1ns / 1ps

module tb;
	import acsp_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int SETTLE      = 80;
	localparam int RANDOM_BYTES = 28;

	typedef struct packed {
		logic       kind;
		logic [7:0] tbyte;
		logic [3:0] idx;
		logic       tend;
		logic [1:0] ctype;
		logic [4:0] total;
		logic [1:0] status;
		logic       last;
	} result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [ADDR_W-1:0]    paddr = '0;
	logic [PDATA_W-1:0]   pwdata = '0;
	logic [PDATA_W-1:0]   prdata;
	logic                 pready;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [7:0]           s_tdata = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [TDATA_W-1:0]   m_tdata;
	logic [0:0]           m_tuser;
	logic                 m_tlast;

	// parser state as the testbench sees it
	phase_t     cmd_phase;
	logic       in_quote;
	logic       escape_seen;
	logic [7:0] token_buf [0:MAX_TOKEN-1];
	int         token_len;
	int         found_params;
	logic       parse_error;
	logic [3:0] type_mask;
	logic [3:0] fewest_params;
	logic [3:0] most_params;

	result_t    pending_results [$];
	logic [7:0] text_q [$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int mismatches = 0;
	int cycles = 0;
	int bytes_sent = 0;
	int tokens_seen = 0;
	int reports_seen = 0;
	int settings_used = 0;

	at_command_suffix_parser i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
			         pending_results.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		m_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
	end

	// ---------------- predictor ----------------

	function automatic status_t route(cmd_type_t t, int cnt);
		if (!type_mask[t])
			return ST_FWD;
		if (t == TY_PARA && (cnt < int'(fewest_params) || cnt > int'(most_params)))
			return ST_FWD;
		return ST_LOCAL;
	endfunction

	function automatic void clear_parse();
		cmd_phase    = PH_FIRST;
		in_quote     = 1'b0;
		escape_seen  = 1'b0;
		token_len    = 0;
		found_params = 0;
		parse_error  = 1'b0;
	endfunction

	function automatic void close_command(cmd_type_t t, int total, status_t st);
		result_t r;
		r        = '0;
		r.kind   = KIND_REPORT;
		r.ctype  = t;
		r.total  = 5'(total);
		r.status = st;
		pending_results.push_back(r);
		clear_parse();
	endfunction

	function automatic void keep_char(logic [7:0] c);
		if (token_len < MAX_TOKEN) begin
			token_buf[token_len] = c;
			token_len++;
		end
	endfunction

	function automatic void release_token();
		result_t r;
		if (token_len == 0)
			return;
		if (found_params >= MAX_PARAMS) begin
			parse_error = 1'b1;
			token_len   = 0;
			return;
		end
		for (int i = 0; i < token_len; i++) begin
			r       = '0;
			r.kind  = KIND_TOKEN;
			r.tbyte = token_buf[i];
			r.idx   = 4'(found_params);
			r.tend  = (i == token_len - 1);
			pending_results.push_back(r);
		end
		found_params++;
		token_len = 0;
	endfunction

	function automatic void param_char(logic [7:0] c);
		if (parse_error) begin
			if (c == CH_NUL)
				close_command(TY_PARA, found_params, ST_ERR);
			return;
		end
		if (escape_seen) begin
			escape_seen = 1'b0;
			if (c == CH_QUOTE) begin
				keep_char(c);
				return;
			end
		end
		if (c == CH_QUOTE && !in_quote) begin
			token_len = 0;
			in_quote  = 1'b1;
			return;
		end
		if (c == CH_QUOTE || c == CH_NUL || (c == CH_COMMA && !in_quote)) begin
			if (c == CH_QUOTE)
				in_quote = 1'b0;
			release_token();
			if (c != CH_NUL)
				return;
			if (parse_error || in_quote)
				close_command(TY_PARA, found_params, ST_ERR);
			else
				close_command(TY_PARA, found_params, route(TY_PARA, found_params));
			return;
		end
		if (c == CH_BSLASH && in_quote) begin
			escape_seen = 1'b1;
			keep_char(c);
			return;
		end
		if (c == CH_SPACE && !in_quote && token_len == 0)
			return;
		keep_char(c);
	endfunction

	function automatic void parse_suffix_byte(logic [7:0] c);
		int      before_n;
		result_t r;
		before_n = pending_results.size();
		case (cmd_phase)
			PH_AFTER_EQ: begin
				if (c == CH_QM) begin
					cmd_phase = PH_TEST;
				end else begin
					cmd_phase = PH_PARAMS;
					param_char(c);
				end
			end
			PH_PARAMS: param_char(c);
			PH_READ: if (c == CH_NUL) close_command(TY_READ, 0, route(TY_READ, 0));
			PH_TEST: if (c == CH_NUL) close_command(TY_TEST, 0, route(TY_TEST, 0));
			PH_BAD:  if (c == CH_NUL) close_command(TY_ACT, 0, ST_ERR);
			default: begin
				if (c == CH_NUL) begin
					close_command(TY_ACT, 0, route(TY_ACT, 0));
				end else if (c == CH_EQ) begin
					cmd_phase = PH_AFTER_EQ;
				end else if (c == CH_QM) begin
					cmd_phase = PH_READ;
				end else begin
					cmd_phase   = PH_BAD;
					parse_error = 1'b1;
				end
			end
		endcase
		if (pending_results.size() > before_n) begin
			r      = pending_results.pop_back();
			r.last = 1'b1;
			pending_results.push_back(r);
		end
	endfunction

	function automatic string show(result_t r);
		return {$sformatf("kind %0d byte %h idx %0d end %0d", r.kind, r.tbyte, r.idx, r.tend),
		        $sformatf(" type %0d total %0d status %0d last %0d", r.ctype, r.total,
		                  r.status, r.last)};
	endfunction

	// ---------------- monitor ----------------

	always @(posedge clk) begin : result_check
		result_t got;
		result_t want;
		logic    bad;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				parse_suffix_byte(s_tdata);
			if (m_tvalid && m_tready) begin
				got.kind   = m_tuser[0];
				got.tbyte  = m_tdata[7:0];
				got.idx    = m_tdata[11:8];
				got.tend   = m_tdata[12];
				got.ctype  = m_tdata[14:13];
				got.total  = m_tdata[19:15];
				got.status = m_tdata[21:20];
				got.last   = m_tlast;
				if (got.kind === KIND_REPORT)
					reports_seen++;
				else
					tokens_seen++;
				if (pending_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: %s", show(got));
				end else begin
					want = pending_results.pop_front();
					bad = (got.kind !== want.kind) || (got.tbyte !== want.tbyte) ||
					      (got.idx !== want.idx) || (got.tend !== want.tend) ||
					      (got.ctype !== want.ctype) || (got.total !== want.total) ||
					      (got.status !== want.status) || (got.last !== want.last);
					if (bad) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("mismatch at cycle %0d", cycles);
							$display("  exp: %s", show(want));
							$display("  got: %s", show(got));
						end
					end
				end
			end
		end
	end

	// ---------------- drivers ----------------

	task automatic send_byte(logic [7:0] b);
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		bytes_sent++;
	endtask

	task automatic send_str(string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	task automatic send_text();
		foreach (text_q[i])
			send_byte(text_q[i]);
	endtask

	// stop sending, let every result drain and the flush logic settle
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic reg_write(reg_idx_t r, logic [3:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {r, 2'b00};
		pwdata  <= PDATA_W'(v);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (r)
			RG_ALLOWED: type_mask = v;
			RG_MIN:     fewest_params = v;
			default:    most_params = v;
		endcase
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic reg_check(reg_idx_t r, logic [3:0] exp_val);
		logic [PDATA_W-1:0] rd;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {r, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		if (rd !== PDATA_W'(exp_val)) begin
			mismatches++;
			if (mismatches <= 10)
				$display("register %0d read %h, expected %h", r, rd, exp_val);
		end
	endtask

	task automatic apply_setting(logic [3:0] mask, logic [3:0] lo, logic [3:0] hi);
		wait_idle();
		reg_write(RG_ALLOWED, mask);
		reg_write(RG_MIN, lo);
		reg_write(RG_MAX, hi);
		settings_used++;
	endtask

	// ---------------- random command text ----------------

	function automatic logic [7:0] plain_char();
		int r;
		r = $urandom_range(99);
		if (r < 50) return 8'($urandom_range(8'h61, 8'h7A));
		if (r < 80) return 8'($urandom_range(8'h30, 8'h39));
		if (r < 88) return CH_SPACE;
		return 8'($urandom_range(1, 255));
	endfunction

	function automatic void add_junk();
		int n;
		n = $urandom_range(0, 3);
		repeat (n) text_q.push_back(8'($urandom_range(1, 255)));
	endfunction

	function automatic void add_token();
		int r;
		int len;
		int q;
		r   = $urandom_range(99);
		len = ($urandom_range(15) == 0) ? $urandom_range(28, 40) : $urandom_range(0, 6);
		if ($urandom_range(3) == 0)
			repeat ($urandom_range(1, 2)) text_q.push_back(CH_SPACE);
		if (r < 55) begin
			repeat (len) text_q.push_back(plain_char());
		end else if (r < 85) begin
			text_q.push_back(CH_QUOTE);
			repeat (len) begin
				q = $urandom_range(99);
				if (q < 10) text_q.push_back(CH_COMMA);
				else if (q < 18) text_q.push_back(CH_SPACE);
				else if (q < 26) begin
					text_q.push_back(CH_BSLASH);
					text_q.push_back(CH_QUOTE);
				end else text_q.push_back(plain_char());
			end
			if ($urandom_range(9) != 0)
				text_q.push_back(CH_QUOTE);
		end else if (r < 93) begin
			repeat (len) text_q.push_back(8'($urandom_range(1, 255)));
		end
	endfunction

	function automatic void build_command();
		int         r;
		int         ntok;
		logic [7:0] b;
		text_q.delete();
		r = $urandom_range(99);
		if (r < 8) begin
		end else if (r < 16) begin
			text_q.push_back(CH_QM);
			add_junk();
		end else if (r < 24) begin
			text_q.push_back(CH_EQ);
			text_q.push_back(CH_QM);
			add_junk();
		end else if (r < 32) begin
			do b = 8'($urandom_range(1, 255)); while (b == CH_EQ || b == CH_QM);
			text_q.push_back(b);
			add_junk();
		end else begin
			text_q.push_back(CH_EQ);
			ntok = ($urandom_range(19) == 0) ? $urandom_range(14, 18) : $urandom_range(0, 5);
			for (int i = 0; i < ntok; i++) begin
				if (i != 0)
					text_q.push_back(CH_COMMA);
				add_token();
			end
		end
		text_q.push_back(CH_NUL);
	endfunction

	task automatic run_commands(int nbytes);
		int start;
		start = bytes_sent;
		while (bytes_sent - start < nbytes) begin
			build_command();
			send_text();
		end
	endtask

	// ---------------- tests ----------------

	task automatic test_registers();
		reg_check(RG_ALLOWED, 4'hF);
		reg_check(RG_MIN, 4'h0);
		reg_check(RG_MAX, 4'hF);
		reg_write(RG_ALLOWED, 4'h0);
		reg_write(RG_MIN, 4'hF);
		reg_write(RG_MAX, 4'h0);
		reg_check(RG_ALLOWED, 4'h0);
		reg_check(RG_MIN, 4'hF);
		reg_check(RG_MAX, 4'h0);
		reg_write(RG_ALLOWED, 4'hF);
		reg_write(RG_MIN, 4'h0);
		reg_write(RG_MAX, 4'hF);
		reg_check(RG_ALLOWED, 4'hF);
		reg_check(RG_MIN, 4'h0);
		reg_check(RG_MAX, 4'hF);
	endtask

	// action, read, test, a bad first byte with extreme byte values and an empty parameter list
	task automatic test_command_types();
		send_byte(CH_NUL);
		send_str("?");
		send_byte(CH_NUL);
		send_str("=?");
		send_byte(8'hFF);
		send_byte(CH_NUL);
		send_byte(8'hFF);
		send_byte(8'h80);
		send_byte(CH_NUL);
		send_str("=");
		send_byte(CH_NUL);
	endtask

	// quoting, escapes, skipped spaces, empty tokens, unterminated string
	task automatic test_tokens();
		send_str("= a,\"b,\\\"c\",,d");
		send_byte(CH_NUL);
		send_str("=xy\"q\"");
		send_byte(CH_NUL);
		send_str("=\"ab");
		send_byte(CH_NUL);
	endtask

	// truncated long token, sixteen parameters, eighteen (two too many)
	task automatic test_limits();
		send_str("=");
		for (int i = 0; i < 40; i++)
			send_byte(8'h41 + 8'(i % 26));
		send_str(",z");
		send_byte(CH_NUL);
		send_str("=");
		for (int i = 0; i < 16; i++) begin
			send_byte(8'h61 + 8'(i));
			if (i != 15)
				send_byte(CH_COMMA);
		end
		send_byte(CH_NUL);
		send_str("=");
		for (int i = 0; i < 17; i++)
			send_str("k,");
		send_str("m");
		send_byte(CH_NUL);
	endtask

	task automatic test_config_sweep();
		apply_setting(4'h0, 4'h0, 4'h0);
		run_commands(10);
		apply_setting(4'hF, 4'hF, 4'hF);
		run_commands(10);
		apply_setting(4'b0101, 4'd2, 4'd3);
		run_commands(10);
		apply_setting(4'b1010, 4'd0, 4'd15);
		run_commands(10);
		apply_setting(4'hF, 4'd3, 4'd1);
		run_commands(10);
		apply_setting(4'hF, 4'd0, 4'd15);
	endtask

	task automatic random_phase(int idle, int stall);
		apply_setting(4'($urandom_range(15)), 4'($urandom_range(0, 3)),
		              4'($urandom_range(2, 15)));
		send_idle_pct  = idle;
		recv_stall_pct = stall;
		run_commands(RANDOM_BYTES / 2);
		wait_idle();
		run_commands(RANDOM_BYTES / 2);
	endtask

	task automatic test_random();
		random_phase(0, 0);
		random_phase(67, 0);
		random_phase(0, 67);
		random_phase(37, 37);
		send_idle_pct  = 0;
		recv_stall_pct = 0;
	endtask

	initial begin
		type_mask     = 4'hF;
		fewest_params = 4'h0;
		most_params   = 4'hF;
		clear_parse();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_registers();
		test_command_types();
		test_tokens();
		send_idle_pct  = 37;
		recv_stall_pct = 37;
		test_limits();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		test_config_sweep();
		test_random();
		wait_idle();

		$display("Sent %0d text bytes under %0d register settings and four idle/stall mixes;",
		         bytes_sent, settings_used);
		$display("checked %0d token bytes and %0d command reports, %0d mismatches.",
		         tokens_seen, reports_seen, mismatches);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
